// File: rtl/pfr_pkg.sv
// Shared constants, types and helpers for the pattern find-and-replace stream.
package pfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int OCC_W       = 16;
  localparam int WORD_W      = MAX_PATTERN * BYTE_W;
  localparam int APB_DW      = 64;
  localparam int APB_AW      = 5;
  localparam int OUT_DW      = 32;

  localparam logic [1:0] REG_PATTERN     = 2'd0;
  localparam logic [1:0] REG_REPLACEMENT = 2'd1;
  localparam logic [1:0] REG_LENGTH      = 2'd2;

  localparam logic [OCC_W-1:0] OCC_MAX = '1;

  // window cell control
  typedef struct packed {
    logic upd;
    logic shift;
  } win_ctl_t;

  // output cell control
  typedef struct packed {
    logic load;
    logic shift;
  } out_ctl_t;

  // length in use, clamped to 1..MAX_PATTERN
  function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    logic [FILL_W-1:0] r;
    if (l == '0) begin
      r = FILL_W'(1);
    end else if (l > LEN_W'(MAX_PATTERN)) begin
      r = FILL_W'(MAX_PATTERN);
    end else begin
      r = FILL_W'(l);
    end
    return r;
  endfunction

endpackage

// File: rtl/pfr_win_cell.sv
// Window cell: holds one byte of the search window and compares it with its pattern byte.
module pfr_win_cell (
  input  logic                       clk_i,
  input  pfr_pkg::win_ctl_t          ctl_i,
  input  logic                       sel_i,
  input  logic [pfr_pkg::BYTE_W-1:0] in_byte_i,
  input  logic [pfr_pkg::BYTE_W-1:0] nb_byte_i,
  input  logic [pfr_pkg::BYTE_W-1:0] pat_byte_i,
  input  logic                       use_i,
  output logic [pfr_pkg::BYTE_W-1:0] byte_o,
  output logic                       eq_o
);

  logic [pfr_pkg::BYTE_W-1:0] byte_q, byte_d;

  // byte after the new request is appended
  assign byte_o = sel_i ? in_byte_i : byte_q;
  assign eq_o   = (byte_o == pat_byte_i) | ~use_i;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.upd) begin
      byte_d = ctl_i.shift ? nb_byte_i : byte_o;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// File: rtl/pfr_out_cell.sv
// Output cell: one slot of the result line, loaded in parallel and drained towards slot 0.
module pfr_out_cell (
  input  logic                       clk_i,
  input  pfr_pkg::out_ctl_t          ctl_i,
  input  logic [pfr_pkg::BYTE_W-1:0] ld_byte_i,
  input  logic                       ld_last_i,
  input  logic [pfr_pkg::BYTE_W-1:0] nb_byte_i,
  input  logic                       nb_last_i,
  output logic [pfr_pkg::BYTE_W-1:0] byte_o,
  output logic                       last_o
);

  logic [pfr_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       last_q, last_d;

  always_comb begin
    byte_d = byte_q;
    last_d = last_q;
    if (ctl_i.load) begin
      byte_d = ld_byte_i;
      last_d = ld_last_i;
    end else if (ctl_i.shift) begin
      byte_d = nb_byte_i;
      last_d = nb_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign byte_o = byte_q;
  assign last_o = last_q;

endmodule

// File: rtl/pattern_find_replace_stream.sv
// Top level: streaming leftmost non-overlapping find and replace of a byte pattern.
//
//  channel  | dir | handshake            | payload
//  s_axis   | in  | tvalid/tready        | tdata[7:0] in_byte, tlast in_last
//  m_axis   | out | tvalid/tready        | tdata out_byte/count/found, tlast out_last
//  apb      | in  | psel/penable/pready  | 0x00 pattern, 0x08 replacement, 0x10 length
//
//  One request is taken per cycle while each gives at most one result byte and m_axis is ready.
//  A match or a last byte loads up to MAX_PATTERN result bytes at once into
//  the output line; the input then waits while the extra bytes drain.
//  A request is taken when the output line is empty or its final byte leaves.
//  Reset clears fill, count and output occupancy; window bytes are not reset.
module pattern_find_replace_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // stream in
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] in_byte
  input  logic                        s_axis_tlast_i,
  // stream out
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [pfr_pkg::OUT_DW-1:0]  m_axis_tdata_o,  // [7:0] out_byte, [23:8] occurrence_count,
                                                       // [24] pattern_found, rest zero
  output logic                        m_axis_tlast_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfr_pkg::APB_AW-1:0]  paddr,
  input  logic [pfr_pkg::APB_DW-1:0]  pwdata,
  output logic [pfr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int M  = pfr_pkg::MAX_PATTERN;
  localparam int BW = pfr_pkg::BYTE_W;
  localparam int FW = pfr_pkg::FILL_W;

  // configuration registers
  logic [pfr_pkg::WORD_W-1:0] pat_q, rep_q;
  logic [pfr_pkg::LEN_W-1:0]  len_q;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      rep_q <= '0;
      len_q <= pfr_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        pfr_pkg::REG_PATTERN:     pat_q <= pwdata[pfr_pkg::WORD_W-1:0];
        pfr_pkg::REG_REPLACEMENT: rep_q <= pwdata[pfr_pkg::WORD_W-1:0];
        pfr_pkg::REG_LENGTH:      len_q <= pwdata[pfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pfr_pkg::REG_PATTERN:     prdata = pat_q;
      pfr_pkg::REG_REPLACEMENT: prdata = rep_q;
      pfr_pkg::REG_LENGTH:      prdata = pfr_pkg::APB_DW'(len_q);
      default:                  prdata = '0;
    endcase
  end

  // control state
  logic [FW-1:0]             fill_q, fill_d;
  logic [FW-1:0]             ocnt_q, ocnt_d;
  logic [pfr_pkg::OCC_W-1:0] tot_q, tot_d, tot_hit, bcnt_q, bcnt_d;

  logic          acc_in, pop, last, full, hit;
  logic [FW-1:0] len, newfill, nres;

  assign len     = pfr_pkg::eff_len(len_q);
  assign newfill = fill_q + FW'(1);
  assign full    = (newfill == len);
  assign last    = s_axis_tlast_i;

  assign m_axis_tvalid_o = (ocnt_q != '0);
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = (ocnt_q == '0) | ((ocnt_q == FW'(1)) & m_axis_tready_i);
  assign acc_in          = s_axis_tvalid_i & s_axis_tready_o;

  // window chain
  logic [M-1:0]    eq;
  logic [BW-1:0]   wbyte [M];
  logic [BW-1:0]   wnb   [M];
  pfr_pkg::win_ctl_t wctl;

  assign hit       = full & (&eq);
  assign wctl.upd  = acc_in & ~hit & ~last;
  assign wctl.shift = full;

  for (genvar k = 0; k < M; k++) begin : g_win
    if (k == M - 1) begin : g_end
      assign wnb[k] = '0;
    end else begin : g_mid
      assign wnb[k] = wbyte[k+1];
    end
    pfr_win_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (wctl),
      .sel_i      (fill_q == FW'(k)),
      .in_byte_i  (s_axis_tdata_i[BW-1:0]),
      .nb_byte_i  (wnb[k]),
      .pat_byte_i (pat_q[k*BW +: BW]),
      .use_i      (FW'(k) < len),
      .byte_o     (wbyte[k]),
      .eq_o       (eq[k])
    );
  end

  // result count for this request
  always_comb begin
    if (hit) begin
      nres = len;
    end else if (full) begin
      nres = last ? len : FW'(1);
    end else begin
      nres = last ? newfill : '0;
    end
  end

  assign tot_hit = (hit && tot_q != pfr_pkg::OCC_MAX) ? tot_q + pfr_pkg::OCC_W'(1) : tot_q;

  always_comb begin
    fill_d = fill_q;
    tot_d  = tot_q;
    bcnt_d = bcnt_q;
    ocnt_d = ocnt_q;
    if (acc_in) begin
      ocnt_d = nres;
      bcnt_d = tot_hit;
      tot_d  = last ? '0 : tot_hit;
      if (hit || last) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = len - FW'(1);
      end else begin
        fill_d = newfill;
      end
    end else if (pop) begin
      ocnt_d = ocnt_q - FW'(1);
    end
    if (cfg_wr && cfg_idx == pfr_pkg::REG_LENGTH) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      tot_q  <= '0;
      bcnt_q <= '0;
      ocnt_q <= '0;
    end else begin
      fill_q <= fill_d;
      tot_q  <= tot_d;
      bcnt_q <= bcnt_d;
      ocnt_q <= ocnt_d;
    end
  end

  // output chain
  pfr_pkg::out_ctl_t octl;
  logic [BW-1:0] obyte [M];
  logic [M-1:0]  olast;
  logic [BW-1:0] onb   [M];
  logic [M-1:0]  onl;

  assign octl.load  = acc_in;
  assign octl.shift = pop;

  for (genvar k = 0; k < M; k++) begin : g_out
    if (k == M - 1) begin : g_end
      assign onb[k] = '0;
      assign onl[k] = 1'b0;
    end else begin : g_mid
      assign onb[k] = obyte[k+1];
      assign onl[k] = olast[k+1];
    end
    pfr_out_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (octl),
      .ld_byte_i (hit ? rep_q[k*BW +: BW] : wbyte[k]),
      .ld_last_i (last & (nres == FW'(k + 1))),
      .nb_byte_i (onb[k]),
      .nb_last_i (onl[k]),
      .byte_o    (obyte[k]),
      .last_o    (olast[k])
    );
  end

  assign m_axis_tlast_o = olast[0];
  assign m_axis_tdata_o = {7'b0, (bcnt_q != '0), bcnt_q, obyte[0]};

endmodule
